>>> src/infix_expression_evaluator_defines.svh
// Assertion helpers shared by the evaluator RTL
`ifndef INFIX_EXPRESSION_EVALUATOR_DEFINES_SVH
`define INFIX_EXPRESSION_EVALUATOR_DEFINES_SVH

// same-cycle implication
`define IEE_ASSERT_SAME(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("iee assertion failed");

// next-cycle implication
`define IEE_ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("iee assertion failed");

`endif

>>> src/iee_pkg.sv
package iee_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int TABLE_ROWS  = 32;
    localparam int CELLS       = TABLE_ROWS * 4;
    localparam int CELL_AW     = $clog2(CELLS);
    localparam int SP_W        = $clog2(STACK_DEPTH + 1);
    localparam int SI_W        = $clog2(STACK_DEPTH);

    localparam int DIVIDEND_W  = 48;
    localparam int DIVISOR_W   = 32;
    localparam int DCNT_W      = $clog2(DIVIDEND_W + 1);

    localparam logic [2:0] OP_LPAREN = 3'd0;
    localparam logic [2:0] OP_ADD    = 3'd1;
    localparam logic [2:0] OP_SUB    = 3'd2;
    localparam logic [2:0] OP_MUL    = 3'd3;
    localparam logic [2:0] OP_DIV    = 3'd4;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DIV0 = 2'd1;
    localparam logic [1:0] ST_OVF  = 2'd2;
    localparam logic [1:0] ST_MAL  = 2'd3;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_LPAR  = 8'h28;
    localparam logic [7:0] CH_RPAR  = 8'h29;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UZ    = 8'h5A;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LZ    = 8'h7A;
    localparam logic [7:0] CASE_GAP = 8'h20;

    typedef struct packed {
        logic capture;
        logic wr_cell;
        logic char_step;
        logic disp;
        logic ref_push;
        logic red_start;
        logic mul_wr;
        logic div_wr;
        logic pop_op;
        logic flag_mal;
        logic push_op;
        logic end_num;
        logic finish;
    } iee_cmd_t;

    typedef struct packed {
        logic last;
        logic pend_digit;
        logic digit;
        logic is_rpar;
        logic is_op;
        logic op_nz;
        logic top_lp;
        logic prec_ge;
        logic red_mul;
        logic red_div_go;
        logic div_done;
        logic m_valid;
    } iee_stat_t;

endpackage

>>> src/iee_ram.sv
module iee_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> src/iee_div.sv
`include "infix_expression_evaluator_defines.svh"

module iee_div (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [iee_pkg::DIVIDEND_W-1:0] dividend,
    input  logic [iee_pkg::DIVISOR_W-1:0]  divisor,
    output logic [iee_pkg::DIVIDEND_W-1:0] quotient,
    output logic                           done
);
    import iee_pkg::*;

    logic [DIVISOR_W:0]    rem_reg, rem_next;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIVISOR_W-1:0]  den_reg;
    logic [DCNT_W-1:0]     cnt_reg;
    logic                  busy_reg, done_reg;
    logic [DIVISOR_W:0]    shifted;

    // restoring, one quotient bit a cycle
    always_comb begin
        shifted  = {rem_reg[DIVISOR_W-1:0], quo_reg[DIVIDEND_W-1]};
        rem_next = shifted;
        quo_next = {quo_reg[DIVIDEND_W-2:0], 1'b0};
        if (shifted >= {1'b0, den_reg}) begin
            rem_next    = shifted - {1'b0, den_reg};
            quo_next[0] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= DCNT_W'(DIVIDEND_W);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == DCNT_W'(1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
            den_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

    `IEE_ASSERT_NEXT(a_start_clears_done, aclk, aresetn, start, !done_reg && busy_reg)

endmodule

>>> src/iee_dp.sv
`include "infix_expression_evaluator_defines.svh"

module iee_dp (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  iee_pkg::iee_cmd_t      cmd,
    output iee_pkg::iee_stat_t     stat,
    input  logic [4:0]             s_cell_row,
    input  logic [1:0]             s_cell_column,
    input  logic signed [31:0]     s_cell_value,
    input  logic [7:0]             s_char_code,
    input  logic                   s_last_char,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic signed [31:0]     m_result_value,
    output logic [1:0]             m_status
);
    import iee_pkg::*;

    localparam logic signed [63:0] SAT_MAX = 64'sd2147483647;
    localparam logic signed [63:0] SAT_MIN = -64'sd2147483648;

    function automatic logic signed [31:0] sat64(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > SAT_MAX) r = 32'sh7FFFFFFF;
        else if (v < SAT_MIN) r = 32'sh80000000;
        else r = v[31:0];
        return r;
    endfunction

    function automatic logic [1:0] prec(input logic [2:0] op);
        logic [1:0] p;
        case (op)
            OP_ADD, OP_SUB: p = 2'd1;
            OP_MUL, OP_DIV: p = 2'd2;
            default:        p = 2'd0;
        endcase
        return p;
    endfunction

    // control state
    logic [SP_W-1:0]  vt_reg, ot_reg;
    logic             pend_v_reg, innum_reg, last_reg;
    logic [31:0]      acc_reg;
    logic [1:0]       err_reg;
    logic [CELLS-1:0] cvalid_reg;
    logic             m_valid_reg;

    // payload
    logic [7:0]         char_reg, pend_c_reg;
    logic signed [31:0] vstk [STACK_DEPTH];
    logic [2:0]         ostk [STACK_DEPTH];
    logic signed [31:0] tos_reg;
    logic signed [63:0] prod_reg;
    logic               neg_reg, ref_hit_reg, cvalid_rd_reg;
    logic signed [31:0] m_result_reg;
    logic [1:0]         m_status_reg;

    logic               digit, upper, lower, letter, is_lpar, is_rpar, is_op;
    logic [2:0]         cur_op, op_top;
    logic [3:0]         dval, row_m1;
    logic [7:0]         letter_up, col;
    logic               ref_ok;
    logic [11:0]        ref_lin, wr_lin;
    logic [CELL_AW-1:0] ref_addr, wr_addr;
    logic               wr_ok;
    logic [SP_W-1:0]    vt_m2, ot_m1;
    logic [SI_W-1:0]    sec_idx, ot_idx;
    logic               vt_full, ot_full, vt_ge2, op_nz;
    logic signed [31:0] a_val;
    logic signed [63:0] a64, b64;
    logic [35:0]        acc36, acc_sum;
    logic [31:0]        acc_next;
    logic [31:0]        a_mag, b_mag;
    logic [DIVIDEND_W-1:0] quo;
    logic signed [63:0] quo_s;
    logic               div_done, div_go;
    logic               push_req, res_we;
    logic signed [31:0] push_data, res_data;
    logic [1:0]         flag_code;
    logic [31:0]        ram_rdata;

    assign digit   = (char_reg >= CH_ZERO) && (char_reg <= CH_NINE);
    assign upper   = (char_reg >= CH_UA) && (char_reg <= CH_UZ);
    assign lower   = (char_reg >= CH_LA) && (char_reg <= CH_LZ);
    assign letter  = upper || lower;
    assign is_lpar = (char_reg == CH_LPAR);
    assign is_rpar = (char_reg == CH_RPAR);
    assign dval    = 4'(char_reg - CH_ZERO);

    always_comb begin
        case (char_reg)
            CH_PLUS:  cur_op = OP_ADD;
            CH_MINUS: cur_op = OP_SUB;
            CH_STAR:  cur_op = OP_MUL;
            CH_SLASH: cur_op = OP_DIV;
            default:  cur_op = OP_LPAREN;
        endcase
    end
    assign is_op = (cur_op != OP_LPAREN);

    // cell reference: column letter A-D either case, row digit 1-9
    assign letter_up = (pend_c_reg >= CH_LA) ? pend_c_reg - CASE_GAP : pend_c_reg;
    assign col       = letter_up - CH_UA;
    assign row_m1    = dval - 4'd1;
    assign ref_ok    = (col < 8'd4) && (dval != 4'd0) && (32'(row_m1) < TABLE_ROWS);
    assign ref_lin   = {6'd0, row_m1, col[1:0]};
    assign ref_addr  = ref_lin[CELL_AW-1:0];
    assign wr_lin    = {5'd0, s_cell_row, s_cell_column};
    assign wr_addr   = wr_lin[CELL_AW-1:0];
    assign wr_ok     = cmd.wr_cell && (32'(s_cell_row) < TABLE_ROWS);

    assign vt_m2   = vt_reg - SP_W'(2);
    assign ot_m1   = ot_reg - SP_W'(1);
    assign sec_idx = vt_m2[SI_W-1:0];
    assign ot_idx  = ot_m1[SI_W-1:0];
    assign vt_full = (vt_reg == SP_W'(STACK_DEPTH));
    assign ot_full = (ot_reg == SP_W'(STACK_DEPTH));
    assign vt_ge2  = (vt_reg >= SP_W'(2));
    assign op_nz   = (ot_reg != '0);
    assign op_top  = ostk[ot_idx];
    assign a_val   = vstk[sec_idx];
    assign a64     = 64'(a_val);
    assign b64     = 64'(tos_reg);
    assign div_go  = vt_ge2 && (op_top == OP_DIV) && (tos_reg != 32'sd0);

    assign acc36    = 36'(acc_reg);
    assign acc_sum  = (acc36 << 3) + (acc36 << 1) + (36'(dval) << 16);
    assign acc_next = (acc_sum > 36'h07FFFFFFF) ? 32'h7FFFFFFF : acc_sum[31:0];

    assign a_mag = a_val[31] ? 32'(-a_val) : 32'(a_val);
    assign b_mag = tos_reg[31] ? 32'(-tos_reg) : 32'(tos_reg);
    assign quo_s = neg_reg ? -$signed({16'd0, quo}) : $signed({16'd0, quo});

    always_comb begin
        push_req  = 1'b0;
        push_data = '0;
        res_we    = 1'b0;
        res_data  = '0;
        flag_code = ST_OK;
        if ((cmd.char_step && !pend_v_reg && !digit && innum_reg) ||
            (cmd.end_num && innum_reg)) begin
            push_req  = 1'b1;
            push_data = $signed(acc_reg);
        end
        if (cmd.ref_push) begin
            push_req  = 1'b1;
            push_data = (ref_hit_reg && cvalid_rd_reg) ? $signed(ram_rdata) : 32'sd0;
        end
        if (push_req && vt_full) flag_code = ST_OVF;
        if (((cmd.disp && is_lpar) || cmd.push_op) && ot_full) flag_code = ST_OVF;
        if (cmd.red_start) begin
            if (!vt_ge2) begin
                flag_code = ST_MAL;
            end else begin
                case (op_top)
                    OP_ADD: begin
                        res_we   = 1'b1;
                        res_data = sat64(a64 + b64);
                    end
                    OP_SUB: begin
                        res_we   = 1'b1;
                        res_data = sat64(a64 - b64);
                    end
                    OP_MUL: res_we = 1'b0;
                    OP_DIV: begin
                        if (tos_reg == 32'sd0) begin
                            res_we    = 1'b1;
                            flag_code = ST_DIV0;
                        end
                    end
                    default: res_we = 1'b1;
                endcase
            end
        end
        if (cmd.mul_wr) begin
            res_we   = 1'b1;
            res_data = sat64(prod_reg >>> 16);
        end
        if (cmd.div_wr) begin
            res_we   = 1'b1;
            res_data = sat64(quo_s);
        end
        if (cmd.flag_mal) flag_code = ST_MAL;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vt_reg      <= '0;
            ot_reg      <= '0;
            pend_v_reg  <= 1'b0;
            innum_reg   <= 1'b0;
            last_reg    <= 1'b0;
            acc_reg     <= '0;
            err_reg     <= ST_OK;
            cvalid_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (wr_ok) cvalid_reg[wr_addr] <= 1'b1;
            if (cmd.capture) last_reg <= s_last_char;
            if (cmd.char_step) begin
                pend_v_reg <= 1'b0;
                if (digit && !pend_v_reg) begin
                    acc_reg   <= acc_next;
                    innum_reg <= 1'b1;
                end else if (!digit) begin
                    acc_reg   <= '0;
                    innum_reg <= 1'b0;
                end
            end
            if (cmd.disp && letter) pend_v_reg <= 1'b1;
            if (((cmd.disp && is_lpar) || cmd.push_op) && !ot_full) ot_reg <= ot_reg + 1'b1;
            if (cmd.pop_op || cmd.red_start) ot_reg <= ot_m1;
            if (push_req && !vt_full) vt_reg <= vt_reg + 1'b1;
            if (res_we) vt_reg <= vt_reg - 1'b1;
            if (cmd.end_num) begin
                pend_v_reg <= 1'b0;
                acc_reg    <= '0;
                innum_reg  <= 1'b0;
            end
            if (err_reg == ST_OK) err_reg <= flag_code;
            if (m_valid_reg && m_ready) m_valid_reg <= 1'b0;
            if (cmd.finish) begin
                m_valid_reg <= 1'b1;
                vt_reg      <= '0;
                ot_reg      <= '0;
                pend_v_reg  <= 1'b0;
                acc_reg     <= '0;
                innum_reg   <= 1'b0;
                err_reg     <= ST_OK;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) char_reg <= s_char_code;
        if (cmd.char_step && pend_v_reg && digit) begin
            ref_hit_reg   <= ref_ok;
            cvalid_rd_reg <= cvalid_reg[ref_addr];
        end
        if (cmd.disp && letter) pend_c_reg <= char_reg;
        if (cmd.disp && is_lpar && !ot_full) ostk[ot_reg[SI_W-1:0]] <= OP_LPAREN;
        if (cmd.push_op && !ot_full) ostk[ot_reg[SI_W-1:0]] <= cur_op;
        if (cmd.red_start) begin
            prod_reg <= a64 * b64;
            neg_reg  <= a_val[31] ^ tos_reg[31];
        end
        if (push_req && !vt_full) begin
            vstk[vt_reg[SI_W-1:0]] <= push_data;
            tos_reg                <= push_data;
        end
        if (res_we) begin
            vstk[sec_idx] <= res_data;
            tos_reg       <= res_data;
        end
        if (cmd.finish) begin
            m_result_reg <= (vt_reg != '0) ? tos_reg : 32'sd0;
            if (err_reg != ST_OK) m_status_reg <= err_reg;
            else if (vt_reg != SP_W'(1)) m_status_reg <= ST_MAL;
            else m_status_reg <= ST_OK;
        end
    end

    iee_ram #(.WIDTH(32), .DEPTH(CELLS)) u_cells (
        .aclk  (aclk),
        .we    (wr_ok),
        .waddr (wr_addr),
        .wdata (s_cell_value),
        .raddr (ref_addr),
        .rdata (ram_rdata)
    );

    iee_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.red_start && div_go),
        .dividend ({a_mag, 16'd0}),
        .divisor  (b_mag),
        .quotient (quo),
        .done     (div_done)
    );

    assign stat.last       = last_reg;
    assign stat.pend_digit = pend_v_reg && digit;
    assign stat.digit      = digit;
    assign stat.is_rpar    = is_rpar;
    assign stat.is_op      = is_op;
    assign stat.op_nz      = op_nz;
    assign stat.top_lp     = (op_top == OP_LPAREN);
    assign stat.prec_ge    = prec(op_top) >= prec(cur_op);
    assign stat.red_mul    = vt_ge2 && (op_top == OP_MUL);
    assign stat.red_div_go = div_go;
    assign stat.div_done   = div_done;
    assign stat.m_valid    = m_valid_reg;

    assign m_valid        = m_valid_reg;
    assign m_result_value = m_result_reg;
    assign m_status       = m_status_reg;

    `IEE_ASSERT_NEXT(a_finish_clears, aclk, aresetn, cmd.finish, (vt_reg == '0) && (ot_reg == '0) && (err_reg == ST_OK) && m_valid_reg)
    `IEE_ASSERT_SAME(a_mul_after_reduce, aclk, aresetn, cmd.mul_wr, $past(cmd.red_start))
    `IEE_ASSERT_SAME(a_vt_bound, aclk, aresetn, res_we, vt_ge2)

endmodule

>>> src/iee_ctrl.sv
module iee_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_func,
    input  logic               m_ready,
    input  iee_pkg::iee_stat_t stat,
    output iee_pkg::iee_cmd_t  cmd,
    output logic               s_ready
);
    import iee_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CHAR  = 4'd1;
    localparam logic [3:0] S_REFRD = 4'd2;
    localparam logic [3:0] S_DISP  = 4'd3;
    localparam logic [3:0] S_RPAR  = 4'd4;
    localparam logic [3:0] S_OPL   = 4'd5;
    localparam logic [3:0] S_FIN   = 4'd6;
    localparam logic [3:0] S_ENDL  = 4'd7;
    localparam logic [3:0] S_DONE  = 4'd8;
    localparam logic [3:0] S_MULW  = 4'd9;
    localparam logic [3:0] S_DIVW  = 4'd10;

    logic [3:0] state_reg, state_next;
    logic [3:0] ret_reg, ret_next;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        ret_next   = ret_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    if (!s_func) begin
                        cmd.wr_cell = 1'b1;
                    end else begin
                        cmd.capture = 1'b1;
                        state_next  = S_CHAR;
                    end
                end
            end
            S_CHAR: begin
                cmd.char_step = 1'b1;
                if (stat.pend_digit) state_next = S_REFRD;
                else if (stat.digit) state_next = S_FIN;
                else state_next = S_DISP;
            end
            S_REFRD: begin
                cmd.ref_push = 1'b1;
                state_next   = S_FIN;
            end
            S_DISP: begin
                cmd.disp = 1'b1;
                if (stat.is_rpar) state_next = S_RPAR;
                else if (stat.is_op) state_next = S_OPL;
                else state_next = S_FIN;
            end
            S_RPAR: begin
                if (stat.op_nz && !stat.top_lp) begin
                    cmd.red_start = 1'b1;
                    ret_next      = S_RPAR;
                    if (stat.red_mul) state_next = S_MULW;
                    else if (stat.red_div_go) state_next = S_DIVW;
                end else if (stat.op_nz) begin
                    cmd.pop_op = 1'b1;
                    state_next = S_FIN;
                end else begin
                    cmd.flag_mal = 1'b1;
                    state_next   = S_FIN;
                end
            end
            S_OPL: begin
                if (stat.op_nz && stat.prec_ge) begin
                    cmd.red_start = 1'b1;
                    ret_next      = S_OPL;
                    if (stat.red_mul) state_next = S_MULW;
                    else if (stat.red_div_go) state_next = S_DIVW;
                end else begin
                    cmd.push_op = 1'b1;
                    state_next  = S_FIN;
                end
            end
            S_FIN: begin
                if (stat.last) begin
                    cmd.end_num = 1'b1;
                    state_next  = S_ENDL;
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_ENDL: begin
                if (stat.op_nz) begin
                    if (stat.top_lp) begin
                        cmd.pop_op   = 1'b1;
                        cmd.flag_mal = 1'b1;
                    end else begin
                        cmd.red_start = 1'b1;
                        ret_next      = S_ENDL;
                        if (stat.red_mul) state_next = S_MULW;
                        else if (stat.red_div_go) state_next = S_DIVW;
                    end
                end else begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                // hold while the previous result is still unclaimed
                if (!stat.m_valid || m_ready) begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_MULW: begin
                cmd.mul_wr = 1'b1;
                state_next = ret_reg;
            end
            S_DIVW: begin
                if (stat.div_done) begin
                    cmd.div_wr = 1'b1;
                    state_next = ret_reg;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            ret_reg   <= S_IDLE;
        end else begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);

endmodule

>>> src/infix_expression_evaluator.sv
// Infix expression evaluator, signed Q16.16, one request per character or
// table write. A cell reference does one cell-table read; a ')' or an
// operator also runs the reductions it triggers: + and - directly, * through
// a registered 32x32 multiply, and / through the shared 48-bit restoring
// divider (one quotient bit per cycle), with a division by zero flagged
// without starting it. On the last character the remaining operators are
// reduced the same way before the result is posted; the result waits in an
// output register, and a following final character stalls only if that
// register is still full. The cell table is ready straight out of reset:
// per-cell valid bits make unwritten cells read as zero.
module infix_expression_evaluator (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_func,
    input  logic [4:0]         s_cell_row,
    input  logic [1:0]         s_cell_column,
    input  logic signed [31:0] s_cell_value,
    input  logic [7:0]         s_char_code,
    input  logic               s_last_char,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_result_value,
    output logic [1:0]         m_status
);
    import iee_pkg::*;

    iee_cmd_t  cmd;
    iee_stat_t stat;

    iee_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_func  (s_func),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd),
        .s_ready (s_ready)
    );

    iee_dp u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .stat           (stat),
        .s_cell_row     (s_cell_row),
        .s_cell_column  (s_cell_column),
        .s_cell_value   (s_cell_value),
        .s_char_code    (s_char_code),
        .s_last_char    (s_last_char),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_result_value (m_result_value),
        .m_status       (m_status)
    );

endmodule

>>> tb/infix_expression_evaluator_checker.sv
module infix_expression_evaluator_checker (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic               s_func,
    input  logic [4:0]         s_cell_row,
    input  logic [1:0]         s_cell_column,
    input  logic signed [31:0] s_cell_value,
    input  logic [7:0]         s_char_code,
    input  logic               s_last_char,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic signed [31:0] m_result_value,
    input  logic [1:0]         m_status,
    output int                 error_count,
    output int                 pending_results
);
    timeunit 1ns;
    timeprecision 1ps;
    import iee_pkg::*;

    typedef struct packed {
        logic signed [31:0] value;
        logic [1:0]         status;
    } outcome_t;

    logic signed [31:0] cells [CELLS];
    logic signed [31:0] vals [STACK_DEPTH];
    logic [2:0]         ops [STACK_DEPTH];
    int                 vtop, otop;
    logic signed [31:0] acc;
    logic               in_num;
    logic               letter_valid;
    logic [7:0]         letter;
    logic [1:0]         err;
    outcome_t           awaited [$];

    function automatic logic signed [31:0] clamp(longint v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic int rank(logic [2:0] op);
        if (op == OP_ADD || op == OP_SUB) return 1;
        if (op == OP_MUL || op == OP_DIV) return 2;
        return 0;
    endfunction

    task automatic raise(logic [1:0] code);
        if (err == ST_OK) err = code;
    endtask

    task automatic push_val(logic signed [31:0] v);
        if (vtop >= STACK_DEPTH) raise(ST_OVF);
        else begin
            vals[vtop] = v;
            vtop++;
        end
    endtask

    task automatic push_opr(logic [2:0] op);
        if (otop >= STACK_DEPTH) raise(ST_OVF);
        else begin
            ops[otop] = op;
            otop++;
        end
    endtask

    task automatic reduce();
        logic [2:0] op;
        longint a, b, p;
        logic signed [31:0] r;
        otop--;
        op = ops[otop];
        if (vtop < 2) begin
            raise(ST_MAL);
            return;
        end
        b = vals[vtop-1];
        a = vals[vtop-2];
        vtop -= 2;
        r = 0;
        case (op)
            OP_ADD: r = clamp(a + b);
            OP_SUB: r = clamp(a - b);
            OP_MUL: begin
                p = a * b;
                if (p >= 0) p = p / 65536;
                else p = -((-p + 65535) / 65536);
                r = clamp(p);
            end
            OP_DIV: begin
                if (b == 0) raise(ST_DIV0);
                else r = clamp((a * 65536) / b);
            end
            default: r = 0;
        endcase
        push_val(r);
    endtask

    task automatic flush_number();
        if (in_num) begin
            push_val(acc);
            in_num = 0;
            acc = 0;
        end
    endtask

    task automatic clear_expr();
        vtop = 0;
        otop = 0;
        acc = 0;
        in_num = 0;
        letter_valid = 0;
        err = ST_OK;
    endtask

    task automatic take_char(logic [7:0] c);
        logic is_digit, is_letter;
        logic [7:0] l;
        int col, row;
        logic signed [31:0] v;
        logic [2:0] op;
        is_digit = c >= CH_ZERO && c <= CH_NINE;
        is_letter = (c >= CH_UA && c <= CH_UZ) || (c >= CH_LA && c <= CH_LZ);
        if (letter_valid) begin
            letter_valid = 0;
            if (is_digit) begin
                l = letter;
                if (l >= CH_LA) l = l - CASE_GAP;
                col = l - CH_UA;
                row = c - CH_ZERO;
                v = 0;
                if (col < 4 && row >= 1 && row - 1 < TABLE_ROWS) v = cells[(row-1)*4 + col];
                push_val(v);
                return;
            end
        end
        if (is_digit) begin
            acc = clamp(longint'(acc) * 10 + longint'(c - CH_ZERO) * 65536);
            in_num = 1;
            return;
        end
        flush_number();
        if (is_letter) begin
            letter_valid = 1;
            letter = c;
        end else if (c == CH_LPAR) begin
            push_opr(OP_LPAREN);
        end else if (c == CH_RPAR) begin
            while (otop > 0 && ops[otop-1] != OP_LPAREN) reduce();
            if (otop > 0) otop--;
            else raise(ST_MAL);
        end else begin
            op = OP_LPAREN;
            case (c)
                CH_PLUS:  op = OP_ADD;
                CH_MINUS: op = OP_SUB;
                CH_STAR:  op = OP_MUL;
                CH_SLASH: op = OP_DIV;
                default:  op = OP_LPAREN;
            endcase
            if (op != OP_LPAREN) begin
                while (otop > 0 && rank(ops[otop-1]) >= rank(op)) reduce();
                push_opr(op);
            end
        end
    endtask

    task automatic finish_expr();
        outcome_t o;
        flush_number();
        letter_valid = 0;
        while (otop > 0) begin
            if (ops[otop-1] == OP_LPAREN) begin
                otop--;
                raise(ST_MAL);
            end else begin
                reduce();
            end
        end
        if (vtop != 1) raise(ST_MAL);
        o.value = vtop > 0 ? vals[vtop-1] : 32'sd0;
        o.status = err;
        awaited.push_back(o);
        clear_expr();
    endtask

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t mismatch %s: got %h, want %h", $realtime, what, got, want);
        error_count++;
    endtask

    initial begin
        error_count = 0;
        pending_results = 0;
        foreach (cells[i]) cells[i] = 0;
        clear_expr();
    end

    always @(posedge aclk) begin
        outcome_t o;
        if (aresetn) begin
            // result side first: a request and the result it causes never share an edge
            if (m_valid && m_ready) begin
                if (awaited.size() == 0) begin
                    report("unexpected result", m_result_value, 0);
                end else begin
                    o = awaited.pop_front();
                    if (m_result_value !== o.value) report("result_value", m_result_value, o.value);
                    if (m_status !== o.status) report("status", m_status, o.status);
                end
            end
            if (s_valid && s_ready) begin
                if (!s_func) begin
                    if (s_cell_row < TABLE_ROWS) cells[s_cell_row*4 + s_cell_column] = s_cell_value;
                end else begin
                    take_char(s_char_code);
                    if (s_last_char) finish_expr();
                end
            end
            pending_results = awaited.size();
        end
    end
endmodule

>>> tb/infix_expression_evaluator_tb.sv
module infix_expression_evaluator_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import iee_pkg::*;

    localparam int WATCHDOG = 20000;

    logic               aclk = 0;
    logic               aresetn = 0;
    logic               s_valid = 0;
    logic               s_ready;
    logic               s_func = 0;
    logic [4:0]         s_cell_row = 0;
    logic [1:0]         s_cell_column = 0;
    logic signed [31:0] s_cell_value = 0;
    logic [7:0]         s_char_code = 0;
    logic               s_last_char = 0;
    logic               m_valid;
    logic               m_ready = 0;
    logic signed [31:0] m_result_value;
    logic [1:0]         m_status;
    int                 error_count, pending_results;
    int                 idle_cycles = 0;
    logic               sink_on = 0;

    always #10 aclk = ~aclk;

    infix_expression_evaluator dut (.*);
    infix_expression_evaluator_checker chk (.*);

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("timeout");
            $display("infix_expression_evaluator_tb: done, errors");
            $finish;
        end
    end

    // result side: random stall before each accepted result once sink_on is set
    initial begin
        int gap;
        @(posedge aclk);
        while (1) begin
            gap = sink_on ? $urandom_range(0, 7) : 0;
            if (gap > 0) begin
                m_ready <= 0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    task automatic send(logic func, logic [4:0] row, logic [1:0] col, logic [31:0] v,
                        logic [7:0] c, logic last, logic pause);
        int gap;
        gap = pause ? $urandom_range(0, 7) : 0;
        if (gap > 0) begin
            s_valid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1;
        s_func <= func;
        s_cell_row <= row;
        s_cell_column <= col;
        s_cell_value <= v;
        s_char_code <= c;
        s_last_char <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic put_cell(logic [4:0] row, logic [1:0] col, logic [31:0] v, logic pause);
        send(1'b0, row, col, v, 8'($urandom()), 1'($urandom()), pause);
    endtask

    task automatic put_text(string t, logic pause);
        for (int i = 0; i < t.len(); i++)
            send(1'b1, 5'($urandom()), 2'($urandom()), $urandom(), t[i], i == t.len() - 1,
                 pause);
    endtask

    function automatic byte pick_char();
        int k;
        string opc, par, alpha;
        opc = "+-*/";
        par = "()";
        alpha = "ABCDabcdZq";
        k = $urandom_range(0, 19);
        if (k < 7) return byte'("0" + $urandom_range(0, 9));
        if (k < 11) return opc[$urandom_range(0, 3)];
        if (k < 13) return par[$urandom_range(0, 1)];
        if (k < 16) return alpha[$urandom_range(0, 9)];
        if (k < 17) return " ";
        return byte'($urandom_range(0, 255));
    endfunction

    function automatic string operand();
        int k;
        string s, alpha;
        alpha = "ABCDabcd";
        k = $urandom_range(0, 3);
        if (k == 0) s = $sformatf("%c%0d", alpha[$urandom_range(0, 7)], $urandom_range(1, 9));
        else if (k == 1) s = $sformatf("%0d", $urandom_range(0, 99999));
        else s = $sformatf("%0d", $urandom_range(0, 20));
        return s;
    endfunction

    function automatic string formed(int depth);
        string s, opc;
        int n;
        opc = "+-*/";
        n = $urandom_range(1, 4);
        if (depth < 3 && $urandom_range(0, 3) == 0) s = {"(", formed(depth + 1), ")"};
        else s = operand();
        for (int i = 1; i < n; i++) begin
            if ($urandom_range(0, 4) == 0) s = {s, " "};
            s = $sformatf("%s%c", s, opc[$urandom_range(0, 3)]);
            if (depth < 3 && $urandom_range(0, 3) == 0) s = {s, "(", formed(depth + 1), ")"};
            else s = {s, operand()};
        end
        return s;
    endfunction

    initial begin
        int sent, k, len;
        string t;
        logic pause;
        repeat (9) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: table extremes, every operator, each corner
        put_cell(0, 0, 32'h7fffffff, 0);
        put_cell(0, 1, 32'h80000000, 0);
        put_cell(8, 3, 32'h00018000, 0);
        put_cell(31, 2, 32'h12345678, 0);
        put_text("A1+b1", 0);
        put_text("3*(4-1)/2", 0);
        put_text("d9*2 +z5", 0);
        put_text("a0+e1+x", 0);
        put_text("A1+A1", 0);
        put_text("B1-A1", 0);
        put_text("B1*B1", 0);
        put_text("0-1*3/7", 0);
        put_text("7/0", 0);
        put_text("99999999999", 0);
        put_text("(((((((((((((((((1)))))))))))))))))", 0);
        put_text("1+2+3+4+5+6+7+8+9+1+2+3+4+5+6+7+8", 0);
        put_text("1+*2", 0);
        put_text("(1+2", 0);
        put_text("1)", 0);
        put_text("1 2", 0);
        put_text("1#2$~", 0);
        put_text("+", 0);
        put_text(" ", 0);

        sink_on = 1;
        sent = 0;
        while (sent < 1400) begin
            pause = $urandom_range(0, 3) != 0;
            k = $urandom_range(0, 9);
            if (k < 2) begin
                put_cell(5'($urandom()), 2'($urandom()), $urandom(), pause);
                sent++;
            end else if (k < 8) begin
                t = formed(0);
                put_text(t, pause);
                sent += t.len();
            end else begin
                len = $urandom_range(1, 12);
                for (int i = 0; i < len; i++)
                    send(1'b1, 5'($urandom()), 2'($urandom()), $urandom(), pick_char(),
                         i == len - 1, pause);
                sent += len;
            end
            if (sent > 600 && sent < 640) begin
                s_valid <= 0;
                @(posedge aclk);
                while (pending_results != 0) @(posedge aclk);
                sent = 640;
            end
        end
        s_valid <= 0;
        while (pending_results != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (error_count == 0) $display("infix_expression_evaluator_tb: done, clean");
        else $display("infix_expression_evaluator_tb: done, errors");
        $finish;
    end
endmodule

>>> files.f
+incdir+src
src/iee_pkg.sv
src/iee_ram.sv
src/iee_div.sv
src/iee_dp.sv
src/iee_ctrl.sv
src/infix_expression_evaluator.sv
tb/infix_expression_evaluator_checker.sv
tb/infix_expression_evaluator_tb.sv
